// File: hdl/crtm_pkg.sv
// Package for the CIDR route table match core.
// Holds the table geometry, entry and port structs, codes and mask helpers.
// No dependencies.
package crtm_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_MATCHES = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int NCNT_W      = $clog2(MAX_MATCHES + 1);

  localparam logic [4:0] PLEN_MIN = 5'd8;
  localparam logic [4:0] PLEN_MAX = 5'd30;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [31:0] net;
    logic [4:0]  plen;
    logic [3:0]  ifc;
  } route_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       net;
    logic [4:0]        plen;
    logic [3:0]        ifc;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

  // Top plen bits set; zero length gives an empty mask.
  function automatic logic [31:0] prefix_mask(input logic [4:0] plen);
    logic [31:0] m;
    m = ~(32'hFFFF_FFFF >> plen);
    return m;
  endfunction

  function automatic logic [4:0] clamp_plen(input logic [4:0] plen);
    logic [4:0] p;
    p = plen;
    if (plen < PLEN_MIN) p = PLEN_MIN;
    if (plen > PLEN_MAX) p = PLEN_MAX;
    return p;
  endfunction

endpackage

// File: hdl/crtm_table.sv
// Route table storage: one synchronous memory with registered read data,
// masking on write and the prefix compare on the read data. Uses crtm_pkg.
module crtm_table (
  input  logic                  clk_i,
  input  crtm_pkg::tbl_wr_t     wr_i,
  input  crtm_pkg::tbl_rd_t     rd_i,
  input  logic [31:0]           key_i,
  output crtm_pkg::route_entry_t rd_entry_o,
  output logic                  hit_o
);
  import crtm_pkg::*;

  route_entry_t mem [TABLE_DEPTH];
  route_entry_t rd_q;
  route_entry_t wr_entry;
  logic [4:0]   wr_plen;

  always_comb begin
    wr_plen       = clamp_plen(wr_i.plen);
    wr_entry.net  = wr_i.net & prefix_mask(wr_plen);
    wr_entry.plen = wr_plen;
    wr_entry.ifc  = wr_i.ifc;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_entry;
    end
  end

  // Hold read data while no read is issued, so a stalled scan keeps its entry.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_q <= mem[rd_i.addr];
    end
  end

  assign rd_entry_o = rd_q;
  assign hit_o      = ((key_i ^ rd_q.net) & prefix_mask(rd_q.plen)) == 32'd0;

endmodule

// File: hdl/cidr_route_table_match_core.sv
// CIDR route table match core: route entry writes and full-scan lookups.
// Uses crtm_pkg and crtm_table.
//
// Usage
// - Input channel (in_valid_i / in_stall_o): one beat is one command. A write
//   (command 0) stores entry_address masked to entry_prefix_len (clamped to
//   8..30) and entry_interface at entry_index. A lookup (command 1) scans
//   slots min(entries_in_use, TABLE_DEPTH)-1 down to 0 against lookup_address.
// - Output channel (out_valid_o / out_stall_i): one beat per matching slot,
//   highest slot first, last_o on the final beat. No match gives one beat
//   with found_o=0 and last_o=1. At most MAX_MATCHES beats; overflow_o on the
//   last beat says more matches were dropped.
// - Config: cfg_we_i writes cfg_wdata_i to entries_in_use; write only idle.
// - Timing: a write leaves the block idle, so the next beat may follow right after.
//   A lookup holds the input stalled for its whole scan plus any output stall:
//   one table read per cycle from the single read port, paused while a match waits
//   on a stalled output register. The output register lets the last beat wait for the
//   receiver while the next command is taken.
// - Stall: a new match that needs a stalled output register pauses the scan.
// - Reset: control and entries_in_use clear; the table is undefined until written.
module cidr_route_table_match_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] entry_address_i,
  input  logic [4:0]  entry_prefix_len_i,
  input  logic [3:0]  entry_interface_i,
  input  logic [31:0] lookup_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [9:0]  match_index_o,
  output logic [31:0] match_prefix_o,
  output logic [4:0]  match_prefix_len_o,
  output logic [3:0]  match_interface_o,
  output logic        overflow_o,
  output logic        last_o
);
  import crtm_pkg::*;

  state_e            state_q, state_d;
  logic [10:0]       entries_q;
  logic [31:0]       key_q, key_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rvalid_q, rvalid_d;
  logic [ADDR_W-1:0] rslot_q, rslot_d;
  logic [NCNT_W-1:0] n_q, n_d;
  logic              pend_valid_q, pend_valid_d;
  logic [ADDR_W-1:0] pend_slot_q, pend_slot_d;
  route_entry_t      pend_entry_q, pend_entry_d;
  logic              ovf_q, ovf_d;

  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [9:0]        idx_q, idx_d;
  logic [31:0]       pfx_q, pfx_d;
  logic [4:0]        plen_q, plen_d;
  logic [3:0]        ifc_q, ifc_d;
  logic              oovf_q, oovf_d;
  logic              last_q, last_d;

  tbl_wr_t           tbl_wr;
  tbl_rd_t           tbl_rd;
  route_entry_t      rd_entry;
  logic              tbl_hit;
  logic              hit;
  logic              out_free;
  logic              blocked;
  logic [CNT_W-1:0]  count_lim;

  crtm_table u_table (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_i       (tbl_rd),
    .key_i      (key_q),
    .rd_entry_o (rd_entry),
    .hit_o      (tbl_hit)
  );

  // Config register: entries searched by lookups.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  // Counts above the table size search the whole table.
  assign count_lim = (32'(entries_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(entries_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hit        = rvalid_q && tbl_hit;

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    rvalid_d     = rvalid_q;
    rslot_d      = rslot_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_entry_d = pend_entry_q;
    ovf_d        = ovf_q;

    out_valid_d  = out_valid_q;
    found_d      = found_q;
    idx_d        = idx_q;
    pfx_d        = pfx_q;
    plen_d       = plen_q;
    ifc_d        = ifc_q;
    oovf_d       = oovf_q;
    last_d       = last_q;

    tbl_wr       = '0;
    tbl_rd       = '0;
    blocked      = 1'b0;

    // Drop the output beat once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_WRITE) begin
            tbl_wr.en   = (32'(entry_index_i) < TABLE_DEPTH);
            tbl_wr.addr = ADDR_W'(entry_index_i);
            tbl_wr.net  = entry_address_i;
            tbl_wr.plen = entry_prefix_len_i;
            tbl_wr.ifc  = entry_interface_i;
          end else begin
            key_d        = lookup_address_i;
            cnt_d        = count_lim;
            rvalid_d     = 1'b0;
            n_d          = '0;
            pend_valid_d = 1'b0;
            ovf_d        = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (hit && (n_q == NCNT_W'(MAX_MATCHES))) begin
          // One match beyond the limit: flag it and stop scanning.
          ovf_d    = 1'b1;
          rvalid_d = 1'b0;
          state_d  = ST_FINISH;
        end else if (!rvalid_q && (cnt_q == '0)) begin
          state_d = ST_FINISH;
        end else begin
          blocked = hit && pend_valid_q && !out_free;
          if (!blocked) begin
            if (hit) begin
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                found_d     = 1'b1;
                idx_d       = 10'(pend_slot_q);
                pfx_d       = pend_entry_q.net;
                plen_d      = pend_entry_q.plen;
                ifc_d       = pend_entry_q.ifc;
                oovf_d      = 1'b0;
                last_d      = 1'b0;
              end
              pend_valid_d = 1'b1;
              pend_slot_d  = rslot_q;
              pend_entry_d = rd_entry;
              n_d          = n_q + NCNT_W'(1);
            end
            if (cnt_q != '0) begin
              tbl_rd.en   = 1'b1;
              tbl_rd.addr = ADDR_W'(cnt_q - CNT_W'(1));
              rslot_d     = ADDR_W'(cnt_q - CNT_W'(1));
              rvalid_d    = 1'b1;
              cnt_d       = cnt_q - CNT_W'(1);
            end else begin
              rvalid_d = 1'b0;
            end
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = pend_valid_q;
          idx_d       = pend_valid_q ? 10'(pend_slot_q) : 10'd0;
          pfx_d       = pend_valid_q ? pend_entry_q.net : 32'd0;
          plen_d      = pend_valid_q ? pend_entry_q.plen : 5'd0;
          ifc_d       = pend_valid_q ? pend_entry_q.ifc : 4'd0;
          oovf_d      = ovf_q;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rvalid_q     <= 1'b0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rvalid_q     <= rvalid_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    rslot_q      <= rslot_d;
    pend_slot_q  <= pend_slot_d;
    pend_entry_q <= pend_entry_d;
    found_q      <= found_d;
    idx_q        <= idx_d;
    pfx_q        <= pfx_d;
    plen_q       <= plen_d;
    ifc_q        <= ifc_d;
    oovf_q       <= oovf_d;
    last_q       <= last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = found_q;
  assign match_index_o      = idx_q;
  assign match_prefix_o     = pfx_q;
  assign match_prefix_len_o = plen_q;
  assign match_interface_o  = ifc_q;
  assign overflow_o         = oovf_q;
  assign last_o             = last_q;

endmodule

// File: hdl/crtm_checker.sv
// Port-level checks for cidr_route_table_match_core, attached by bind.
// Depends on the top level's ports only.
module crtm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        found_o,
  input logic [9:0]  match_index_o,
  input logic [31:0] match_prefix_o,
  input logic        overflow_o,
  input logic        last_o
);

  // A stalled beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(match_index_o)
      && $stable(match_prefix_o) && $stable(last_o))
    else $error("stalled output beat changed");

  // A not-found beat is the only beat of its lookup and carries zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o && !overflow_o
      && (match_index_o == 10'd0) && (match_prefix_o == 32'd0))
    else $error("not-found beat malformed");

  // Overflow appears only on the final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> last_o && found_o)
    else $error("overflow on a non-final beat");

  // While a lookup still owes beats the input stays stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken before lookup finished");

endmodule

bind cidr_route_table_match_core crtm_checker u_crtm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .match_index_o  (match_index_o),
  .match_prefix_o (match_prefix_o),
  .overflow_o     (overflow_o),
  .last_o         (last_o)
);

// File: test/cidr_route_table_match_core_tb.sv
// Self-checking testbench for cidr_route_table_match_core: a directed table of beats,
// then random phases of route writes and lookups, checked against an in-bench route table.
// Depends on crtm_pkg and the core RTL only.
`timescale 1ns / 100ps

module cidr_route_table_match_core_tb;
  import crtm_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 12;      // let a trailing write retire before a register write
  localparam int TAIL_CYCLES   = 24;      // quiet window after the last expected beat
  localparam int LONG_HOLD     = 300;     // receiver hold-off, long enough to back up the input
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_CAP    = 200;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;

  // One input beat as the sender drives it.
  typedef struct packed {
    logic        cmd;
    logic [9:0]  slot;
    logic [31:0] addr;
    logic [4:0]  plen;
    logic [3:0]  ifc;
    logic [31:0] key;
  } route_cmd_t;

  // One output beat as the receiver sees it.
  typedef struct packed {
    logic        found;
    logic [9:0]  idx;
    logic [31:0] prefix;
    logic [4:0]  plen;
    logic [3:0]  ifc;
    logic        overflow;
    logic        last;
  } route_hit_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [10:0] span;       // entries_in_use for a config row
    route_cmd_t  beat;
    logic        fixed_exp;  // lookup result typed in below instead of predicted
    route_hit_t  hit;
  } dir_row_t;

  localparam route_hit_t NO_ROUTE     = '{1'b0, 10'd0, 32'h0, 5'd0, 4'd0, 1'b0, 1'b1};
  localparam route_hit_t HIT_TEN_NET  = '{1'b1, 10'd5, 32'h0A00_0000, 5'd8, 4'd1, 1'b0, 1'b1};
  localparam route_hit_t HIT_ZERO_NET = '{1'b1, 10'd2, 32'h0, 5'd30, 4'd5, 1'b0, 1'b1};
  localparam route_hit_t HIT_FOUR_NET = '{1'b1, 10'd2, 32'h4, 5'd30, 4'd9, 1'b0, 1'b1};

  localparam int DIR_ROWS = 21;

  // Directed table. Empty-range, no-match and single-match lookups carry their expected beat;
  // the multi-match rows go through the predictor.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty search range after reset
    '{ROW_CFG,  11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'h0000_0000}, 1'b1, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'hFFFF_FFFF}, 1'b1, NO_ROUTE},
    // prefix length below the floor clamps to 8, above the ceiling clamps to 30
    '{ROW_BEAT, 11'd0, '{CMD_WRITE, 10'd0, 32'hFFFF_FFFF, 5'd0, 4'd15, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_WRITE, 10'd1, 32'hFFFF_FFFF, 5'd31, 4'd0, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_WRITE, 10'd2, 32'h0000_0000, 5'd30, 4'd5, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_WRITE, 10'd3, 32'hC0A8_01FF, 5'd24, 4'd3, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_WRITE, 10'd4, 32'hC0A8_FFFF, 5'd16, 4'd7, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_WRITE, 10'd5, 32'h0A0B_0C0D, 5'd8, 4'd1, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_WRITE, 10'd1023, 32'h5A5A_5A5A, 5'd7, 4'd10, 32'h0}, 1'b0, NO_ROUTE},
    // entries exist but nothing is searched yet
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'hFFFF_FFFF}, 1'b1, NO_ROUTE},
    '{ROW_CFG,  11'd6, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'hFFFF_FFFF}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'hFFFF_FFFE}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'hC0A8_0142}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'h0A00_0000}, 1'b1, HIT_TEN_NET},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'h0000_0003}, 1'b1, HIT_ZERO_NET},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'h0000_0004}, 1'b1, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'h7F00_0001}, 1'b1, NO_ROUTE},
    // overwrite a slot and see the new entry
    '{ROW_BEAT, 11'd0, '{CMD_WRITE, 10'd2, 32'h0000_0004, 5'd30, 4'd9, 32'h0}, 1'b0, NO_ROUTE},
    '{ROW_BEAT, 11'd0, '{CMD_LOOKUP, 10'd0, 32'h0, 5'd0, 4'd0, 32'h0000_0007}, 1'b1, HIT_FOUR_NET}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [9:0]  entry_index_i;
  logic [31:0] entry_address_i;
  logic [4:0]  entry_prefix_len_i;
  logic [3:0]  entry_interface_i;
  logic [31:0] lookup_address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        found_o;
  logic [9:0]  match_index_o;
  logic [31:0] match_prefix_o;
  logic [4:0]  match_prefix_len_o;
  logic [3:0]  match_interface_o;
  logic        overflow_o;
  logic        last_o;

  // In-bench copy of the route table and the search-range register.
  route_entry_t route_copy   [TABLE_DEPTH];
  bit           slot_loaded  [TABLE_DEPTH];
  logic [10:0]  in_use_model;

  route_hit_t   pending_hits [$];   // expected output beats, oldest first
  route_hit_t   front_hit;
  logic [31:0]  net_pool [4];       // networks that random entries and keys cluster around

  int  fail_count     = 0;
  int  cycle_count    = 0;
  int  tx_burst       = 0;
  int  rx_burst       = 0;
  bit  hold_off_armed = 1'b0;

  cidr_route_table_match_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .entry_index_i      (entry_index_i),
    .entry_address_i    (entry_address_i),
    .entry_prefix_len_i (entry_prefix_len_i),
    .entry_interface_i  (entry_interface_i),
    .lookup_address_i   (lookup_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .found_o            (found_o),
    .match_index_o      (match_index_o),
    .match_prefix_o     (match_prefix_o),
    .match_prefix_len_o (match_prefix_len_o),
    .match_interface_o  (match_interface_o),
    .overflow_o         (overflow_o),
    .last_o             (last_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Hard stop: far beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cidr_route_table_match_core verification failed");
      $finish;
    end
  end

  // Top prefix-length bits set; stored lengths are always 8..30.
  function automatic logic [31:0] route_netmask(input logic [4:0] plen);
    return 32'hFFFF_FFFF << (32 - plen);
  endfunction

  // Gap before the next beat on either side: mostly random, with runs of back-to-back.
  function automatic int pick_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Address near one of the pool networks: random host bits under at least an 8-bit prefix.
  function automatic logic [31:0] near_pool();
    logic [31:0] base;
    base = net_pool[$urandom_range(0, 3)];
    return base ^ ($urandom >> $urandom_range(8, 32));
  endfunction

  function automatic route_cmd_t rand_write(input logic [9:0] slot);
    route_cmd_t c;
    c.cmd  = CMD_WRITE;
    c.slot = slot;
    c.addr = ($urandom_range(0, 3) != 0) ? near_pool() : 32'($urandom);
    // mostly legal lengths; now and then one that must clamp
    c.plen = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(8, 30));
    c.ifc  = 4'($urandom_range(0, 15));
    c.key  = $urandom;
    return c;
  endfunction

  function automatic route_cmd_t rand_lookup();
    route_cmd_t c;
    c.cmd  = CMD_LOOKUP;
    c.slot = 10'($urandom_range(0, TABLE_DEPTH - 1));
    c.addr = $urandom;
    c.plen = 5'($urandom_range(0, 31));
    c.ifc  = 4'($urandom_range(0, 15));
    c.key  = ($urandom_range(0, 3) != 0) ? near_pool() : 32'($urandom);
    return c;
  endfunction

  function automatic void reseed_pool();
    for (int p = 0; p < 4; p++) net_pool[p] = $urandom;
  endfunction

  // Route table behavior: a write updates the copy, a lookup queues its output beats.
  function automatic void advance_route_model(input route_cmd_t c);
    logic [4:0]  p;
    logic [31:0] m;
    route_hit_t  held;
    bit          have;
    bit          dropped;
    int          n;
    int          reach;
    if (c.cmd == CMD_WRITE) begin
      p = c.plen;
      if (p < PLEN_MIN) p = PLEN_MIN;
      if (p > PLEN_MAX) p = PLEN_MAX;
      route_copy[c.slot].net  = c.addr & route_netmask(p);
      route_copy[c.slot].plen = p;
      route_copy[c.slot].ifc  = c.ifc;
      slot_loaded[c.slot]     = 1'b1;
      return;
    end
    // Scan from the top slot down; hold back the newest hit so the final one gets last.
    reach   = (in_use_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(in_use_model);
    have    = 1'b0;
    dropped = 1'b0;
    n       = 0;
    held    = NO_ROUTE;
    for (int s = reach - 1; s >= 0 && !dropped; s--) begin
      m = route_netmask(route_copy[s].plen);
      if ((c.key & m) == route_copy[s].net) begin
        if (n == MAX_MATCHES) begin
          dropped = 1'b1;
        end else begin
          if (have) pending_hits.push_back(held);
          held.found    = 1'b1;
          held.idx      = 10'(s);
          held.prefix   = route_copy[s].net;
          held.plen     = route_copy[s].plen;
          held.ifc      = route_copy[s].ifc;
          held.overflow = 1'b0;
          held.last     = 1'b0;
          have          = 1'b1;
          n++;
        end
      end
    end
    if (have) begin
      held.overflow = dropped;
      held.last     = 1'b1;
    end
    pending_hits.push_back(held);
  endfunction

  // Offer one beat, hold it until accepted, then advance the model. Entered and left at a
  // falling edge; valid stays high on exit so a back-to-back beat needs no re-raise.
  task automatic send_beat(input route_cmd_t c, input bit use_fixed, input route_hit_t fixed_hit);
    int gap;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= c.cmd;
    entry_index_i      <= c.slot;
    entry_address_i    <= c.addr;
    entry_prefix_len_i <= c.plen;
    entry_interface_i  <= c.ifc;
    lookup_address_i   <= c.key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (c.cmd == CMD_LOOKUP && use_fixed) pending_hits.push_back(fixed_hit);
    else advance_route_model(c);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every expected beat, then let a trailing write retire.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_in_use(input logic [10:0] span);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= span;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    in_use_model  = span;
  endtask

  // One random phase: set the search range, load every slot it covers that is still blank
  // (a lookup must never read an unwritten slot), then mix writes and lookups.
  task automatic run_phase(input logic [10:0] span, input int n_items, input int lookup_pct,
                           input bit arm_hold);
    int         reach;
    route_cmd_t c;
    drain_results();
    write_in_use(span);
    reach = (span > TABLE_DEPTH) ? TABLE_DEPTH : int'(span);
    for (int i = 0; i < reach; i++) begin
      if (!slot_loaded[i]) send_beat(rand_write(10'(i)), 1'b0, NO_ROUTE);
    end
    if (arm_hold) hold_off_armed = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < lookup_pct) c = rand_lookup();
      else if (reach > 0 && $urandom_range(0, 3) != 0)
        c = rand_write(10'($urandom_range(0, reach - 1)));
      else
        c = rand_write(10'($urandom_range(0, TABLE_DEPTH - 1)));
      send_beat(c, 1'b0, NO_ROUTE);
      // now and then hold the input until the output side has caught up
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // Output checker: every accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP)
          $display("%0t: unexpected beat, expected none, actual found=%0b slot=%0d last=%0b",
                   $time, found_o, match_index_o, last_o);
      end else begin
        front_hit = pending_hits.pop_front();
        check_field("found",            32'(front_hit.found),    32'(found_o));
        check_field("match_index",      32'(front_hit.idx),      32'(match_index_o));
        check_field("match_prefix",     front_hit.prefix,        match_prefix_o);
        check_field("match_prefix_len", 32'(front_hit.plen),     32'(match_prefix_len_o));
        check_field("match_interface",  32'(front_hit.ifc),      32'(match_interface_o));
        check_field("overflow",         32'(front_hit.overflow), 32'(overflow_o));
        check_field("last",             32'(front_hit.last),     32'(last_o));
      end
    end
  end

  // Receiver: stall a random number of cycles before each beat; once, when the sender arms
  // it, hold off for a long stretch so the block fills and stalls its input.
  initial begin : result_sink
    int gap;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = pick_gap(rx_burst);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin : beat_source
    route_cmd_t c;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    command_i          = CMD_WRITE;
    entry_index_i      = '0;
    entry_address_i    = '0;
    entry_prefix_len_i = '0;
    entry_interface_i  = '0;
    lookup_address_i   = '0;
    in_use_model       = '0;
    reseed_pool();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_CFG) begin
        drain_results();
        write_in_use(DIR_TABLE[r].span);
      end else begin
        send_beat(DIR_TABLE[r].beat, DIR_TABLE[r].fixed_exp, DIR_TABLE[r].hit);
      end
    end

    // Truncation: load slots 0..39 with random hosts of 10.0.0.0/8 (short lengths clamp to
    // 8), so a key in that net matches all of them. Exactly the cap gives no overflow flag;
    // one more slot or several set it.
    for (int s = 0; s < 40; s++) begin
      c = rand_write(10'(s));
      c.addr[31:24] = 8'h0A;
      c.plen        = 5'($urandom_range(0, 8));
      send_beat(c, 1'b0, NO_ROUTE);
    end
    for (int p = 0; p < 4; p++) net_pool[p] = 32'h0A00_0000;
    run_phase(11'd32, 6, 100, 1'b0);
    run_phase(11'd33, 6, 100, 1'b0);
    run_phase(11'd40, 6, 100, 1'b0);

    // Mixed traffic; mostly short search ranges, a few full-table scans.
    reseed_pool();
    run_phase(11'd1, 20, 60, 1'b0);
    reseed_pool();
    run_phase(11'd17, 40, 60, 1'b1);
    reseed_pool();
    run_phase(11'($urandom_range(2, 64)), 40, 50, 1'b0);
    reseed_pool();
    run_phase(11'd64, 40, 60, 1'b0);
    reseed_pool();
    run_phase(11'd1024, 6, 50, 1'b0);
    // a range past the table depth searches every slot
    run_phase(11'd2047, 6, 50, 1'b0);
    run_phase(11'd0, 10, 50, 1'b0);
    reseed_pool();
    run_phase(11'($urandom_range(2, 48)), 40, 60, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("cidr_route_table_match_core verification clean");
    end else begin
      $display("cidr_route_table_match_core verification failed");
    end
    $finish;
  end

endmodule
